### src/mco_pkg.sv
// Shared types, widths and the cost table address map for matrix_chain_order.
// No dependencies; used by mco_cost_eval and matrix_chain_order.
package mco_pkg;

   localparam int MaxMatrices = 8;
   localparam int DimCap      = MaxMatrices + 1;
   localparam int DimW        = 10;
   localparam int IdxW        = 4;
   localparam int CostW       = 40;
   localparam int PairW       = 2 * DimW;
   localparam int ProdW       = 3 * DimW;
   localparam int CostDepth   = DimCap * DimCap;
   localparam int CostAW      = $clog2(CostDepth);

   typedef logic [DimW-1:0]   dim_type;
   typedef logic [IdxW-1:0]   idx_type;
   typedef logic [CostW-1:0]  cost_type;
   typedef logic [CostAW-1:0] cost_addr_type;

   // Control that travels with one candidate split through the evaluator.
   typedef struct packed {
      logic    valid;
      logic    first;
      logic    zero_right;
      idx_type k;
   } eval_ctl_type;

   // Row-major place of entry [a][b] in the cost memory.
   function automatic cost_addr_type cost_addr(input idx_type a, input idx_type b);
      return cost_addr_type'(CostAW'(a) * CostAW'(DimCap) + CostAW'(b));
   endfunction

endpackage

### src/mco_cost_eval.sv
// Candidate split evaluator: product, cost sum and running least-cost compare.
// Depends on mco_pkg; memory read data arrives in the cycle after issue_ctl.
module mco_cost_eval (
   input  logic                      clock,
   input  logic                      reset,
   input  mco_pkg::eval_ctl_type     issue_ctl,
   input  logic [mco_pkg::PairW-1:0] pair_product,
   input  mco_pkg::dim_type          dim_k,
   input  mco_pkg::cost_type         cost_left,
   input  mco_pkg::cost_type         cost_right,
   output mco_pkg::cost_type         best_cost,
   output mco_pkg::idx_type          best_split,
   output logic                      busy
);

   mco_pkg::eval_ctl_type            s1_ctl_ff;
   logic                             s2_valid_ff;
   logic                             s2_first_ff;
   mco_pkg::idx_type                 s2_k_ff;
   logic [mco_pkg::ProdW-1:0]        s2_prod_ff;
   mco_pkg::cost_type                s2_sum_ff;
   mco_pkg::cost_type                best_ff;
   mco_pkg::idx_type                 split_ff;

   logic [mco_pkg::ProdW-1:0]        prod_in;
   mco_pkg::cost_type                sum_in;
   mco_pkg::cost_type                cand;

   // The shortest sub-span on either side has no stored cost; it counts as zero.
   assign sum_in  = (s1_ctl_ff.first ? '0 : cost_left) +
                    (s1_ctl_ff.zero_right ? '0 : cost_right);
   assign prod_in = mco_pkg::ProdW'(pair_product) * mco_pkg::ProdW'(dim_k);
   assign cand    = s2_sum_ff + mco_pkg::CostW'(s2_prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff   <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_ctl_ff   <= issue_ctl;
         s2_valid_ff <= s1_ctl_ff.valid;
      end
      s2_first_ff <= s1_ctl_ff.first;
      s2_k_ff     <= s1_ctl_ff.k;
      s2_prod_ff  <= prod_in;
      s2_sum_ff   <= sum_in;
      // Only a strictly smaller cost replaces the first split found.
      if (s2_valid_ff && (s2_first_ff || cand < best_ff)) begin
         best_ff  <= cand;
         split_ff <= s2_k_ff;
      end
   end

   assign best_cost  = best_ff;
   assign best_split = split_ff;
   assign busy       = s1_ctl_ff.valid | s2_valid_ff;

endmodule

### src/matrix_chain_order.sv
// A dimension beat is taken whenever the block is loading. After the last beat, each span
// of matrices reads its two end dimensions, forms their product, issues each split to the
// evaluator with one cost memory read per split, waits for the evaluator to drain and
// writes back its cost; a chain of one or no matrices gives a single result.
// Throughput: one dimension beat per cycle while loading. Reset clears control state
// only; the dimension and cost memories are not cleared and need no clearing pass.
module matrix_chain_order (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [9:0]             req_dimension,
   input  logic                   req_is_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [3:0]             rsp_span_start,
   output logic [3:0]             rsp_span_end,
   output logic [3:0]             rsp_best_split,
   output logic [39:0]            rsp_span_cost,
   output logic                   rsp_overflow,
   output logic                   rsp_is_final
);

   // The sequencer walks the spans by length and then by start. For each span
   // it fetches the two end dimensions, forms their product once, then issues
   // one split per cycle into the evaluator, together with the two sub-span costs
   // and the split dimension that it reads from the memories.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SHORT,
      ST_RDA,
      ST_RDB,
      ST_PAIR,
      ST_ITER,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type                 state_ff;
   mco_pkg::idx_type          dim_count_ff;
   logic                      dropped_ff;
   mco_pkg::idx_type          n_ff;
   mco_pkg::idx_type          s_ff;
   mco_pkg::idx_type          a_ff;
   mco_pkg::idx_type          b_ff;
   mco_pkg::idx_type          k_ff;
   mco_pkg::dim_type          da_ff;
   logic [mco_pkg::PairW-1:0] pab_ff;

   logic                      rsp_valid_ff;
   mco_pkg::idx_type          rsp_start_ff;
   mco_pkg::idx_type          rsp_end_ff;
   mco_pkg::idx_type          rsp_split_ff;
   mco_pkg::cost_type         rsp_cost_ff;
   logic                      rsp_overflow_ff;
   logic                      rsp_final_ff;

   // Dimension memory: written while loading, one registered read port.
   mco_pkg::dim_type          dims_mem [mco_pkg::DimCap];
   mco_pkg::dim_type          dims_rd_ff;
   mco_pkg::idx_type          dims_raddr;
   logic                      dims_we;

   // Cost memory: one write port, two registered read ports.
   mco_pkg::cost_type         cost_mem [mco_pkg::CostDepth];
   mco_pkg::cost_type         cost_l_rd_ff;
   mco_pkg::cost_type         cost_r_rd_ff;
   mco_pkg::cost_addr_type    cost_waddr;
   logic                      cost_we;

   logic                      req_beat;
   logic                      out_free;
   logic                      rsp_load;
   logic                      has_room;
   mco_pkg::idx_type          count_in;
   mco_pkg::idx_type          n_in;
   logic                      is_final_span;
   mco_pkg::eval_ctl_type     issue_ctl;
   mco_pkg::cost_type         best_cost;
   mco_pkg::idx_type          best_split;
   logic                      eval_busy;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_beat  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   // A new result beat enters the output register in this cycle.
   assign rsp_load  = ((state_ff == ST_SHORT) | (state_ff == ST_EMIT)) & out_free;

   // A dimension beyond capacity is dropped but still counts toward the flag.
   assign has_room  = (dim_count_ff < mco_pkg::IdxW'(mco_pkg::DimCap));
   assign count_in  = has_room ? dim_count_ff + 1'b1 : dim_count_ff;
   assign n_in      = count_in - 1'b1;
   assign dims_we   = req_beat & has_room;

   assign is_final_span = (s_ff == n_ff);

   always_comb begin
      case (state_ff)
         ST_RDA:  dims_raddr = a_ff;
         ST_RDB:  dims_raddr = b_ff;
         default: dims_raddr = k_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (dims_we) begin
         dims_mem[dim_count_ff] <= req_dimension;
      end
      dims_rd_ff <= dims_mem[dims_raddr];
   end

   assign cost_we    = (state_ff == ST_EMIT) & out_free;
   assign cost_waddr = mco_pkg::cost_addr(a_ff, b_ff);

   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[cost_waddr] <= best_cost;
      end
      cost_l_rd_ff <= cost_mem[mco_pkg::cost_addr(a_ff, k_ff)];
      cost_r_rd_ff <= cost_mem[mco_pkg::cost_addr(k_ff, b_ff)];
   end

   // The left sub-span of the first split and the right sub-span of the last
   // split are single matrices, whose cost is zero and never stored.
   always_comb begin
      issue_ctl.valid      = (state_ff == ST_ITER);
      issue_ctl.first      = (k_ff == a_ff + 1'b1);
      issue_ctl.zero_right = (b_ff == k_ff + 1'b1);
      issue_ctl.k          = k_ff;
   end

   mco_cost_eval u_eval (
      .clock        (clock),
      .reset        (reset),
      .issue_ctl    (issue_ctl),
      .pair_product (pab_ff),
      .dim_k        (dims_rd_ff),
      .cost_left    (cost_l_rd_ff),
      .cost_right   (cost_r_rd_ff),
      .best_cost    (best_cost),
      .best_split   (best_split),
      .busy         (eval_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         dim_count_ff <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_LOAD: begin
               if (req_beat) begin
                  dim_count_ff <= count_in;
                  if (!has_room) begin
                     dropped_ff <= 1'b1;
                  end
                  if (req_is_last) begin
                     n_ff <= n_in;
                     s_ff <= 4'd2;
                     a_ff <= '0;
                     b_ff <= 4'd2;
                     if (n_in < 4'd2) begin
                        state_ff <= ST_SHORT;
                     end else begin
                        state_ff <= ST_RDA;
                     end
                  end
               end
            end
            ST_SHORT: begin
               // No matrix or a single matrix: one zero-cost result.
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_start_ff    <= '0;
                  rsp_end_ff      <= n_ff;
                  rsp_split_ff    <= '0;
                  rsp_cost_ff     <= '0;
                  rsp_overflow_ff <= dropped_ff;
                  rsp_final_ff    <= 1'b1;
                  dim_count_ff    <= '0;
                  dropped_ff      <= 1'b0;
                  state_ff        <= ST_LOAD;
               end
            end
            ST_RDA: begin
               state_ff <= ST_RDB;
            end
            ST_RDB: begin
               da_ff    <= dims_rd_ff;
               state_ff <= ST_PAIR;
            end
            ST_PAIR: begin
               pab_ff   <= mco_pkg::PairW'(da_ff) * mco_pkg::PairW'(dims_rd_ff);
               k_ff     <= a_ff + 1'b1;
               state_ff <= ST_ITER;
            end
            ST_ITER: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff == b_ff - 1'b1) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!eval_busy) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_start_ff    <= a_ff;
                  rsp_end_ff      <= b_ff;
                  rsp_split_ff    <= best_split;
                  rsp_cost_ff     <= best_cost;
                  rsp_overflow_ff <= dropped_ff;
                  rsp_final_ff    <= is_final_span;
                  if (is_final_span) begin
                     dim_count_ff <= '0;
                     dropped_ff   <= 1'b0;
                     state_ff     <= ST_LOAD;
                  end else if (b_ff + 1'b1 <= n_ff) begin
                     a_ff     <= a_ff + 1'b1;
                     b_ff     <= b_ff + 1'b1;
                     state_ff <= ST_RDA;
                  end else begin
                     s_ff     <= s_ff + 1'b1;
                     a_ff     <= '0;
                     b_ff     <= s_ff + 1'b1;
                     state_ff <= ST_RDA;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_span_start = rsp_start_ff;
   assign rsp_span_end   = rsp_end_ff;
   assign rsp_best_split = rsp_split_ff;
   assign rsp_span_cost  = rsp_cost_ff;
   assign rsp_overflow   = rsp_overflow_ff;
   assign rsp_is_final   = rsp_final_ff;

   // The fill count never runs past the dimension memory.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      dim_count_ff <= mco_pkg::IdxW'(mco_pkg::DimCap))
      else $error("dimension count beyond capacity");

   // A span result must not be written back before its last split is evaluated.
   a_drained_on_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> !eval_busy)
      else $error("span emitted while evaluator still busy");

   // Every result spans forward, except the empty chain's single result.
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_end_ff > rsp_start_ff) || (rsp_final_ff && rsp_end_ff == '0))
      else $error("result span runs backward");

   // A span of two or more matrices splits strictly inside itself.
   a_split_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_end_ff > rsp_start_ff + 1'b1)
      |-> (rsp_split_ff > rsp_start_ff) && (rsp_split_ff < rsp_end_ff))
      else $error("best split outside its span");

endmodule
